/* sv/ufp_pkg.sv */
// ----------------------------------------------------------------------------
// ufp_pkg
// Shared types and constants for the form-urlencoded parser: character
// codes, pair status codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package ufp_pkg;

    // Characters with a special meaning in a query string
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Pair status codes carried on a pair end
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ESC = 2'd1;
    localparam logic [1:0] ST_NO_EQ   = 2'd2;

    // Everything one input byte produces: an optional byte, an optional pair end
    typedef struct packed {
        logic       emit;      // a decoded byte is present
        logic [7:0] obyte;     // decoded byte
        logic       opart;     // byte part: 0 name, 1 value
        logic       closed;    // a pair end follows
        logic       cpart;     // pair end part: 1 if the value was reached
        logic [1:0] cst;       // pair end status
        logic       send;      // pair end was caused by the final byte
    } t_ufp_entry;

endpackage

/* sv/ufp_front.sv */
// ----------------------------------------------------------------------------
// ufp_front
// Accepts query string bytes, tracks the pair phase and escape digit, and
// turns each byte into at most one queue entry (decoded byte and/or pair end).
// ----------------------------------------------------------------------------
module ufp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_q_ready,
    output logic                o_ready,
    output logic                o_push,
    output ufp_pkg::t_ufp_entry o_entry
);
    import ufp_pkg::*;

    typedef enum logic [5:0] {
        PH_BETWEEN = 6'b000001,
        PH_NAME    = 6'b000010,
        PH_VALUE   = 6'b000100,
        PH_PCT1    = 6'b001000,
        PH_PCT2    = 6'b010000,
        PH_SKIP    = 6'b100000
    } t_phase;

    // Bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r = {1'b0, c[3:0] + 4'd9};
            end else begin
                r = 5'h10;
            end
            return r;
        end
    endfunction

    function automatic logic [1:0] close_status(input t_phase p);
        logic [1:0] r;
        begin
            if (p == PH_NAME) begin
                r = ST_NO_EQ;
            end else if (p == PH_VALUE) begin
                r = ST_OK;
            end else begin
                r = ST_BAD_ESC;
            end
            return r;
        end
    endfunction

    t_phase     r_phase, n_phase;
    logic [3:0] r_hex, n_hex;
    t_ufp_entry w_ent;
    logic [4:0] w_d;
    t_phase     w_p;
    logic       w_take;

    assign o_ready = i_q_ready;
    assign w_take  = i_valid && i_q_ready;
    assign w_d     = hex_digit(i_byte);

    // Classify the byte and step the phase
    always_comb begin
        w_ent   = '0;
        n_hex   = r_hex;
        w_p     = r_phase;
        if (i_byte == CH_AMP) begin
            if (r_phase != PH_BETWEEN) begin
                w_ent.closed = 1'b1;
                w_ent.cst    = close_status(r_phase);
                w_ent.cpart  = (r_phase != PH_NAME);
                w_p          = PH_BETWEEN;
            end
        end else begin
            case (r_phase)
                PH_VALUE: begin
                    if (i_byte == CH_PCT) begin
                        w_p = PH_PCT1;
                    end else begin
                        w_ent.emit  = 1'b1;
                        w_ent.opart = 1'b1;
                        w_ent.obyte = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    end
                end
                PH_PCT1: begin
                    if (!w_d[4]) begin
                        n_hex = w_d[3:0];
                        w_p   = PH_PCT2;
                    end else begin
                        w_p = PH_SKIP;
                    end
                end
                PH_PCT2: begin
                    if (!w_d[4]) begin
                        w_ent.emit  = 1'b1;
                        w_ent.opart = 1'b1;
                        w_ent.obyte = {r_hex, w_d[3:0]};
                        w_p         = PH_VALUE;
                    end else begin
                        w_p = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    w_p = PH_SKIP;
                end
                default: begin
                    // between pairs or in the name
                    if (i_byte == CH_EQ) begin
                        w_p = PH_VALUE;
                    end else begin
                        w_ent.emit  = 1'b1;
                        w_ent.obyte = i_byte;
                        w_p         = PH_NAME;
                    end
                end
            endcase
        end

        // Close an open pair on the final byte
        if (i_last && !w_ent.closed && w_p != PH_BETWEEN) begin
            w_ent.closed = 1'b1;
            w_ent.cst    = close_status(w_p);
            w_ent.cpart  = (w_p != PH_NAME);
        end
        w_ent.send = i_last && w_ent.closed;
        n_phase    = i_last ? PH_BETWEEN : w_p;
        if (w_ent.closed) begin
            n_hex = 4'd0;
        end
    end

    assign o_entry = w_ent;
    assign o_push  = w_take && (w_ent.emit || w_ent.closed);

    // Hold state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BETWEEN;
            r_hex   <= 4'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
        end
    end

endmodule

/* sv/ufp_queue.sv */
// ----------------------------------------------------------------------------
// ufp_queue
// Short entry queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module ufp_queue #(
    parameter int QDEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ufp_pkg::t_ufp_entry i_entry,
    input  logic                i_pop,
    output logic                o_ready,
    output logic                o_valid,
    output ufp_pkg::t_ufp_entry o_entry
);
    import ufp_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_ufp_entry    r_mem [QDEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* sv/ufp_back.sv */
// ----------------------------------------------------------------------------
// ufp_back
// Takes queue entries and delivers their results one per transaction:
// the decoded byte first, then the pair end, from an output register.
// ----------------------------------------------------------------------------
module ufp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ufp_pkg::t_ufp_entry i_entry,
    output logic                o_pop,
    input  logic                i_tready,
    output logic                o_tvalid,
    output logic [7:0]          o_byte,
    output logic                o_part,
    output logic                o_pair_end,
    output logic [1:0]          o_status,
    output logic                o_string_end,
    output logic                o_run_last
);
    import ufp_pkg::*;

    t_ufp_entry r_ent;
    logic       r_valid;
    logic       r_sub;       // byte of a two-result entry already sent
    logic       w_show_byte, w_fin, w_load;

    assign w_show_byte = r_ent.emit && !r_sub;
    assign w_fin       = !(w_show_byte && r_ent.closed);
    assign w_load      = !r_valid || (i_tready && w_fin);
    assign o_pop       = w_load && i_valid;

    // Hold the current entry and step through its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
            r_sub   <= 1'b0;
        end else if (i_tready) begin
            r_sub <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    // Drive the current result
    assign o_tvalid     = r_valid;
    assign o_byte       = w_show_byte ? r_ent.obyte : 8'd0;
    assign o_part       = w_show_byte ? r_ent.opart : r_ent.cpart;
    assign o_pair_end   = !w_show_byte;
    assign o_status     = w_show_byte ? ST_OK : r_ent.cst;
    assign o_string_end = w_show_byte ? 1'b0 : r_ent.send;
    assign o_run_last   = w_fin;

endmodule

/* sv/urlencoded_form_parser_top.sv */
// ----------------------------------------------------------------------------
// urlencoded_form_parser_top
// Streaming form-urlencoded query string parser, one byte per transaction in.
// ----------------------------------------------------------------------------
// The parser takes one query string byte per cycle and emits name and value
// bytes (value bytes decoded: '+' to space, '%hh' to a byte) followed by a
// pair end marker with a status for every pair. Input runs at one byte per
// cycle as long as the entry queue of QDEPTH entries has room; the output
// register delivers one result per cycle while m_axis_tready is high, so a
// byte that both yields a character and closes a pair yields two results,
// and a skipped byte yields none. An accepted byte passes through the entry
// queue and then the output register before its first result appears.
module urlencoded_form_parser_top #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                        // [10] string_end, [15:11] zero
    output logic [1:0]  m_axis_tuser,   // [0] part, [1] pair_end
    output logic        m_axis_tlast    // run_last
);
    import ufp_pkg::*;

    t_ufp_entry w_f_entry, w_q_entry;
    logic       w_push, w_q_ready, w_q_valid, w_pop;
    logic [7:0] w_byte;
    logic [1:0] w_status;
    logic       w_part, w_pair_end, w_string_end, w_run_last;

    ufp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_q_ready (w_q_ready),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_entry   (w_f_entry)
    );

    ufp_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_f_entry),
        .i_pop   (w_pop),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    ufp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_entry      (w_q_entry),
        .o_pop        (w_pop),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_byte       (w_byte),
        .o_part       (w_part),
        .o_pair_end   (w_pair_end),
        .o_status     (w_status),
        .o_string_end (w_string_end),
        .o_run_last   (w_run_last)
    );

    // Pack result fields
    assign m_axis_tdata = {5'd0, w_string_end, w_status, w_byte};
    assign m_axis_tuser = {w_pair_end, w_part};
    assign m_axis_tlast = w_run_last;

    // A pair end carries no byte
    a_end_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_pair_end |-> w_byte == 8'd0)
        else $error("pair end carries a byte");

    // A byte result carries no status and no string end
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_pair_end |-> w_status == ST_OK && !w_string_end)
        else $error("byte result carries pair end fields");

    // A byte that is not the last result of its item is followed by its pair end
    a_byte_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !w_pair_end && !w_run_last
        |=> m_axis_tvalid && w_pair_end && w_run_last)
        else $error("pair end lost after byte");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_status != 2'd3)
        else $error("undefined status code");

endmodule
